// File: design/xor_sprite_framebuffer_defines.svh
// assertion macros for the xor sprite framebuffer checker
// no dependencies; included by the checker file only
`ifndef XOR_SPRITE_FRAMEBUFFER_DEFINES_SVH
`define XOR_SPRITE_FRAMEBUFFER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define XSF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xsf check failed");

// next-cycle implication, disabled while reset is low
`define XSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xsf check failed");

// next-cycle implication that also runs through reset
`define XSF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("xsf check failed");

`endif

// File: design/xsf_pkg.sv
// shared constants, request codes and controller/datapath command types
// no dependencies; imported by every module of the framebuffer
`default_nettype none

package xsf_pkg;

  // screen geometry
  localparam int SCREEN_COLUMNS = 64;
  localparam int SCREEN_ROWS    = 32;
  localparam int COL_W          = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W          = $clog2(SCREEN_ROWS);

  // coordinate working width: holds 255 + 15
  localparam int COORD_W        = 9;

  // stream payload widths
  localparam int IN_TDATA_W     = 40;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 40;
  localparam int OUT_WORD_W     = 32;

  // request kinds
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // input transfer, latch the request
    logic reduce;    // one wrap step on column and row
    logic clear_fb;  // blank the whole screen
    logic rd_issue;  // read the requested column
    logic draw_rd;   // read the current sprite column
    logic draw_wr;   // write back the toggled column
    logic advance;   // move to the next sprite pixel
    logic push;      // load the output register
  } xsf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] req;       // latched request code
    logic       in_range;  // column and row both wrapped
    logic       pix_set;   // current sprite pixel is lit
    logic       last_bit;  // current pixel is the rightmost
  } xsf_sts_t;

endpackage

`default_nettype wire

// File: design/xsf_ctrl.sv
// request sequencer and output valid flag for the framebuffer
// depends on xsf_pkg for the command and status types
`default_nettype none

module xsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  xsf_pkg::xsf_sts_t sts,
  output xsf_pkg::xsf_cmd_t cmd
);
  import xsf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DECODE  = 5'b00010,
    S_DRAW_RD = 5'b00100,
    S_DRAW_WR = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load  = in_tvalid && (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.req)
          REQ_CLEAR: begin
            cmd.clear_fb = 1'b1;
            state_nxt    = S_FINISH;
          end
          REQ_DRAW: begin
            if (sts.in_range) begin
              state_nxt = S_DRAW_RD;
            end else begin
              cmd.reduce = 1'b1;
            end
          end
          REQ_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_FINISH;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_DRAW_RD: begin
        if (sts.pix_set) begin
          cmd.draw_rd = 1'b1;
          state_nxt   = S_DRAW_WR;
        end else begin
          cmd.advance = 1'b1;
          if (sts.last_bit) state_nxt = S_FINISH;
        end
      end
      S_DRAW_WR: begin
        cmd.draw_wr = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = sts.last_bit ? S_FINISH : S_DRAW_RD;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/xsf_datapath.sv
// column memory, coordinate wrapping, pixel toggling and result register
// depends on xsf_pkg for geometry constants and command/status types
`default_nettype none

module xsf_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [xsf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [xsf_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  xsf_pkg::xsf_cmd_t               cmd,
  output xsf_pkg::xsf_sts_t               sts,
  output logic [xsf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import xsf_pkg::*;

  localparam logic [COORD_W-1:0] COLS_C = COORD_W'(SCREEN_COLUMNS);
  localparam logic [COORD_W-1:0] ROWS_C = COORD_W'(SCREEN_ROWS);
  localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(SCREEN_COLUMNS - 1);

  // latched request
  logic [1:0]             req_r;
  logic [COORD_W-1:0]     col_r, col_nxt;
  logic [COORD_W-1:0]     row_r, row_nxt;
  logic [7:0]             pix_r;
  logic [2:0]             bit_r;
  logic [COL_W-1:0]       rd_col_r;
  logic                   rd_ok_r;
  logic                   coll_r;

  // column store
  logic [SCREEN_ROWS-1:0] mem [SCREEN_COLUMNS];
  logic [SCREEN_COLUMNS-1:0] valid_r;
  logic [SCREEN_ROWS-1:0] rdata_r;
  logic                   rvalid_r;

  // result register
  logic                   out_coll_r;
  logic [OUT_WORD_W-1:0]  out_word_r;

  logic [COORD_W-1:0]     rd_col_ext;
  logic [COL_W-1:0]       addr;
  logic [SCREEN_ROWS-1:0] mask;
  logic [SCREEN_ROWS-1:0] old_word;
  logic [SCREEN_ROWS-1:0] new_word;
  logic [OUT_WORD_W-1:0]  read_word;

  assign rd_col_ext = COORD_W'(in_tdata[33:28]);
  assign addr       = cmd.rd_issue ? rd_col_r : col_r[COL_W-1:0];
  assign mask       = {{(SCREEN_ROWS-1){1'b0}}, 1'b1} << row_r[ROW_W-1:0];
  assign old_word   = rvalid_r ? rdata_r : '0;
  assign new_word   = old_word ^ mask;
  assign read_word  = (req_r == REQ_READ && rd_ok_r) ? OUT_WORD_W'(old_word) : '0;

  // status back to the sequencer
  assign sts.req      = req_r;
  assign sts.in_range = (col_r < COLS_C) && (row_r < ROWS_C);
  assign sts.pix_set  = pix_r[~bit_r];
  assign sts.last_bit = (bit_r == 3'd7);

  // coordinate wrapping and stepping
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.reduce) begin
      if (col_r >= COLS_C) col_nxt = col_r - COLS_C;
      if (row_r >= ROWS_C) row_nxt = row_r - ROWS_C;
    end else if (cmd.advance) begin
      col_nxt = (col_r == COL_LAST) ? '0 : col_r + 1'b1;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_tuser;
      col_r    <= COORD_W'(in_tdata[7:0]);
      row_r    <= COORD_W'(in_tdata[15:8]) + COORD_W'(in_tdata[19:16]);
      pix_r    <= in_tdata[27:20];
      rd_col_r <= rd_col_ext[COL_W-1:0];
      rd_ok_r  <= (rd_col_ext < COLS_C);
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // sprite pixel counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_r <= 3'd0;
    end else if (cmd.advance) begin
      bit_r <= bit_r + 1'b1;
    end
  end

  // collision flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r <= 1'b0;
    end else if (cmd.load && in_tuser == REQ_DRAW && in_tdata[19:16] == 4'd0) begin
      coll_r <= 1'b0;
    end else if (cmd.draw_wr && (old_word & mask) != '0) begin
      coll_r <= 1'b1;
    end
  end

  // single-port column memory
  always_ff @(posedge clk) begin
    if (cmd.draw_wr) begin
      mem[addr] <= new_word;
    end else if (cmd.draw_rd || cmd.rd_issue) begin
      rdata_r <= mem[addr];
    end
  end

  // per-column written flags, a column not written since clear reads as blank
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_fb) begin
      valid_r <= '0;
    end else if (cmd.draw_wr) begin
      valid_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_rd || cmd.rd_issue) begin
      rvalid_r <= valid_r[addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_coll_r <= coll_r;
      out_word_r <= read_word;
    end
  end

  assign out_tdata = {(OUT_TDATA_W - OUT_WORD_W - 1)'(0), out_word_r, out_coll_r};

endmodule

`default_nettype wire

// File: design/xor_sprite_framebuffer.sv
// 64x32 monochrome framebuffer held as one 32-bit word per column, with a
// clear request, an xor sprite-row draw request (coordinates wrap, a lit pixel
// turned off sets the collision flag, row offset zero restarts it) and a
// column read request; every request returns exactly one result transfer.
// A draw first wraps the coordinates, one wrap step at a time; the number of
// wrap steps is the larger of pos_x / 64 and (pos_y + row_offset) / 32, at
// most 8. It then steps through the 8 sprite pixels, and each lit pixel
// costs a read and a write on the single port of the column memory. One
// request is in progress at a time; the next input transfer is taken while
// a result still waits in the output register. After reset the screen reads
// clear at once.
// depends on xsf_pkg, xsf_ctrl and xsf_datapath
`default_nettype none

module xor_sprite_framebuffer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] pos_x, [15:8] pos_y, [19:16] row_offset, [27:20] row_pixels,
  // [33:28] read_column, [39:34] zero
  input  logic [xsf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [xsf_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] collision, [32:1] column_pixels, [39:33] zero
  output logic [xsf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import xsf_pkg::*;

  xsf_cmd_t cmd;
  xsf_sts_t sts;

  // request sequencer
  xsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // column memory and arithmetic
  xsf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// File: design/xsf_checker.sv
// port-level checks on the framebuffer, bound to the top level
// depends on xsf_pkg and the assertion macros header
`default_nettype none
`include "xor_sprite_framebuffer_defines.svh"

module xsf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [xsf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import xsf_pkg::*;

  // a stalled result keeps its payload
  `XSF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one request at a time: an input transfer closes the input side
  `XSF_ASSERT_NEXT(a_in_busy, in_tvalid && in_tready, !in_tready)

  // a new result appears only as the block returns to accepting input
  `XSF_ASSERT_IMPL(a_push_idle, $rose(out_tvalid), in_tready)

  // reset leaves no result pending and the input open
  `XSF_ASSERT_NEXT_ALWAYS(a_reset, !rst_n, !out_tvalid && in_tready)

endmodule

bind xor_sprite_framebuffer xsf_checker u_xsf_checker (.*);

`default_nettype wire
